/* src/tpdc_pkg.sv */
// Shared constants, types and helper functions for the tangent-plane to
// direction-cosine pipeline. No dependencies.
`default_nettype none

package tpdc_pkg;

    // Width of every port field, two's complement.
    localparam int WORD_BITS  = 32;

    // Restoring square root: one result bit per stage.
    localparam int SQRT_STEPS = 32;
    // Quotient bits produced by the divider, one per stage.
    localparam int QUO_BITS   = 31;
    // Divider pipeline stages: operand prep, one stage per quotient bit, output register.
    localparam int DIV_LAT    = QUO_BITS + 2;
    // Squares, sums, square root, cx/cy divide, products, numerators, final divide.
    localparam int PIPE_DEPTH = 2 + SQRT_STEPS + DIV_LAT + 2 + DIV_LAT;

    localparam logic signed [31:0] ONE_Q30 = 32'sd1 <<< 30;
    localparam logic        [63:0] ONE_Q56 = 64'd1 << 56;

    typedef struct packed {
        logic signed [31:0] xi;
        logic signed [31:0] eta;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vec;

    typedef struct packed {
        t_vec               v;
        logic signed [33:0] ez;   // floor(eta * z / 2^30), Q.28
    } t_carry;

    // Sign-extend a port word and clamp it to the signed 32-bit range.
    function automatic logic signed [31:0] read_in(input logic [WORD_BITS-1:0] w);
        logic signed [63:0] v;
        v = signed'({{(64-WORD_BITS){w[WORD_BITS-1]}}, w});
        if (v > 64'sd2147483647) begin
            return 32'sh7fff_ffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Place a 32-bit signed result on a port word.
    function automatic logic [WORD_BITS-1:0] to_word(input logic signed [31:0] q);
        logic signed [63:0] e;
        e = 64'(q);
        return e[WORD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

/* src/tpdc_if.sv */
// Valid/ready channel interfaces for the tangent-plane pipeline.
// Depends on tpdc_pkg for the word width.
`default_nettype none

interface tpdc_in_if;
    import tpdc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] xi;
    logic [WORD_BITS-1:0] eta;
    logic [WORD_BITS-1:0] tan_x;
    logic [WORD_BITS-1:0] tan_y;
    logic [WORD_BITS-1:0] tan_z;
    modport source (output valid, xi, eta, tan_x, tan_y, tan_z, input ready);
    modport sink   (input valid, xi, eta, tan_x, tan_y, tan_z, output ready);
endinterface

interface tpdc_out_if;
    import tpdc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] star_x;
    logic [WORD_BITS-1:0] star_y;
    logic [WORD_BITS-1:0] star_z;
    modport source (output valid, star_x, star_y, star_z, input ready);
    modport sink   (input valid, star_x, star_y, star_z, output ready);
endinterface

`default_nettype wire

/* src/tpdc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, truncating toward
// zero and saturating to +/-2^30. Depends on tpdc_pkg.
`default_nettype none

module tpdc_div (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [63:0] i_num,
    input  wire logic        [32:0] i_den,
    output logic signed      [31:0] o_quo
);
    import tpdc_pkg::*;

    logic [63:0]         r_rem [QUO_BITS+1];
    logic [QUO_BITS-1:0] r_q   [QUO_BITS+1];
    logic [32:0]         r_den [QUO_BITS+1];
    logic                r_neg [QUO_BITS+1];
    logic                r_ovf [QUO_BITS+1];
    logic [63:0]         n_rem [QUO_BITS+1];
    logic [QUO_BITS-1:0] n_q   [QUO_BITS+1];
    logic [63:0]         w_mag;
    logic [63:0]         w_dsh;
    logic [QUO_BITS-1:0] w_qf;
    logic [QUO_BITS-1:0] w_qs;
    logic signed [31:0]  r_quo;

    assign w_mag = i_num[63] ? 64'(-i_num) : 64'(i_num);

    always_comb begin
        n_rem[0] = w_mag;
        n_q[0]   = '0;
        w_dsh    = '0;
        for (int j = 1; j <= QUO_BITS; j++) begin
            w_dsh    = {31'd0, r_den[j-1]} << (QUO_BITS - j);
            n_rem[j] = r_rem[j-1];
            n_q[j]   = r_q[j-1];
            if (r_rem[j-1] >= w_dsh) begin
                n_rem[j]            = r_rem[j-1] - w_dsh;
                n_q[j][QUO_BITS-j]  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem[0];
            r_q[0]   <= n_q[0];
            r_den[0] <= i_den;
            r_neg[0] <= i_num[63];
            r_ovf[0] <= (w_mag >> QUO_BITS) >= {31'd0, i_den};
            for (int j = 1; j <= QUO_BITS; j++) begin
                r_rem[j] <= n_rem[j];
                r_q[j]   <= n_q[j];
                r_den[j] <= r_den[j-1];
                r_neg[j] <= r_neg[j-1];
                r_ovf[j] <= r_ovf[j-1];
            end
            r_quo <= r_neg[QUO_BITS] ? -signed'({1'b0, w_qs}) : signed'({1'b0, w_qs});
        end
    end

    // Saturate the magnitude to one when the quotient overflows or exceeds one.
    assign w_qf = r_q[QUO_BITS];
    assign w_qs = (r_ovf[QUO_BITS] || (w_qf > QUO_BITS'(ONE_Q30)))
                  ? QUO_BITS'(ONE_Q30) : w_qf;
    assign o_quo = r_quo;

endmodule

`default_nettype wire

/* src/tangent_plane_to_direction_cosines.sv */
// Inverse gnomonic projection: tangent-plane (xi, eta) plus tangent point
// cosines in, star direction cosines out. The pipeline holds tpdc_pkg::PIPE_DEPTH
// stages: two 32-stage square roots side by side, then two 33-stage divides in
// series, plus squares, sums, products and numerators.
// Throughput one item per cycle; a refused result drops into a skid register and
// input stalls while it waits. Synchronous active-low reset clears valid bits only.
`default_nettype none

module tangent_plane_to_direction_cosines (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tpdc_in_if.sink     i_in,
    tpdc_out_if.source  o_out
);
    import tpdc_pkg::*;

    localparam int CR_LAST = SQRT_STEPS + DIV_LAT;

    // Pipeline control: every stage advances together unless the skid is full.
    logic                  w_en;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic                  r_skid_vld;
    logic [WORD_BITS-1:0]  r_skid_x, r_skid_y, r_skid_z;

    // Stage A: clamped inputs and squares.
    t_vec                  w_in;
    t_vec                  r_a_in;
    logic [63:0]           r_a_xi2, r_a_eta2, r_a_x2, r_a_y2;
    logic signed [63:0]    r_a_ez;

    // Carry line from stage B to stage E.
    t_carry                r_cr  [CR_LAST+1];

    // Square root state; index 0 is stage B.
    logic [65:0]           r_frem [SQRT_STEPS+1];
    logic [31:0]           r_fres [SQRT_STEPS+1];
    logic [65:0]           r_rrem [SQRT_STEPS+1];
    logic [31:0]           r_rres [SQRT_STEPS+1];
    logic [65:0]           n_frem [SQRT_STEPS+1];
    logic [31:0]           n_fres [SQRT_STEPS+1];
    logic [65:0]           n_rrem [SQRT_STEPS+1];
    logic [31:0]           n_rres [SQRT_STEPS+1];
    logic [65:0]           w_ft, w_rt;

    // f and r delayed across the cx/cy divide.
    logic [31:0]           r_fd [1:DIV_LAT];
    logic [31:0]           r_rd [1:DIV_LAT];

    logic signed [31:0]    w_cxq, w_cyq, w_cx, w_cy;
    logic signed [63:0]    w_xnum, w_ynum;

    // Stage E: products.
    logic signed [63:0]    r_e_xicy, r_e_xicx;
    logic signed [65:0]    r_e_ezcx, r_e_ezcy;
    logic signed [64:0]    r_e_er;
    logic signed [31:0]    r_e_x, r_e_y, r_e_z;
    logic [31:0]           r_e_f;

    // Stage F: numerators.
    logic signed [63:0]    r_f_n0, r_f_n1, r_f_n2;
    logic [31:0]           r_f_f;
    logic signed [65:0]    w_n0, w_n1, w_n2;

    logic signed [31:0]    w_sx, w_sy, w_sz;
    logic                  w_last;

    assign w_en       = !r_skid_vld;
    assign i_in.ready = w_en;
    assign w_last     = r_vld[PIPE_DEPTH-1];

    assign w_in.xi  = read_in(i_in.xi);
    assign w_in.eta = read_in(i_in.eta);
    assign w_in.x   = read_in(i_in.tan_x);
    assign w_in.y   = read_in(i_in.tan_y);
    assign w_in.z   = read_in(i_in.tan_z);

    // Advance valid bits with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_in.valid};
        end
    end

    // Stage A: squares of the clamped coordinates, eta*z product.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_in   <= w_in;
            r_a_xi2  <= 64'(w_in.xi * w_in.xi);
            r_a_eta2 <= 64'(w_in.eta * w_in.eta);
            r_a_x2   <= 64'(w_in.x * w_in.x);
            r_a_y2   <= 64'(w_in.y * w_in.y);
            r_a_ez   <= 64'(w_in.eta) * 64'(w_in.z);
        end
    end

    // Square root steps: each stage settles one root bit, most significant first.
    always_comb begin
        w_ft = '0;
        w_rt = '0;
        n_frem[0] = {2'b00, r_a_xi2 + r_a_eta2 + ONE_Q56};
        n_fres[0] = '0;
        n_rrem[0] = {2'b00, r_a_x2 + r_a_y2};
        n_rres[0] = '0;
        for (int j = 1; j <= SQRT_STEPS; j++) begin
            w_ft = ({34'd0, r_fres[j-1]} << (SQRT_STEPS - j + 1))
                 + (66'd1 << (2 * (SQRT_STEPS - j)));
            w_rt = ({34'd0, r_rres[j-1]} << (SQRT_STEPS - j + 1))
                 + (66'd1 << (2 * (SQRT_STEPS - j)));
            n_frem[j] = r_frem[j-1];
            n_fres[j] = r_fres[j-1];
            n_rrem[j] = r_rrem[j-1];
            n_rres[j] = r_rres[j-1];
            if (r_frem[j-1] >= w_ft) begin
                n_frem[j]                 = r_frem[j-1] - w_ft;
                n_fres[j][SQRT_STEPS - j] = 1'b1;
            end
            if (r_rrem[j-1] >= w_rt) begin
                n_rrem[j]                 = r_rrem[j-1] - w_rt;
                n_rres[j][SQRT_STEPS - j] = 1'b1;
            end
        end
    end

    // Stage B, the root stages and the carry line.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cr[0].v  <= r_a_in;
            r_cr[0].ez <= 34'(r_a_ez >>> 30);
            for (int j = 1; j <= CR_LAST; j++) begin
                r_cr[j] <= r_cr[j-1];
            end
            for (int j = 0; j <= SQRT_STEPS; j++) begin
                r_frem[j] <= n_frem[j];
                r_fres[j] <= n_fres[j];
                r_rrem[j] <= n_rrem[j];
                r_rres[j] <= n_rres[j];
            end
            r_fd[1] <= r_fres[SQRT_STEPS];
            r_rd[1] <= r_rres[SQRT_STEPS];
            for (int j = 2; j <= DIV_LAT; j++) begin
                r_fd[j] <= r_fd[j-1];
                r_rd[j] <= r_rd[j-1];
            end
        end
    end

    // cx = x/r and cy = y/r in Q.30.
    assign w_xnum = 64'(r_cr[SQRT_STEPS].v.x) <<< 30;
    assign w_ynum = 64'(r_cr[SQRT_STEPS].v.y) <<< 30;

    tpdc_div u_div_cx (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_xnum),
        .i_den ({1'b0, r_rres[SQRT_STEPS]}), .o_quo (w_cxq)
    );
    tpdc_div u_div_cy (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_ynum),
        .i_den ({1'b0, r_rres[SQRT_STEPS]}), .o_quo (w_cyq)
    );

    // At a pole take the right ascension as zero.
    assign w_cx = (r_rd[DIV_LAT] == '0) ? ONE_Q30 : w_cxq;
    assign w_cy = (r_rd[DIV_LAT] == '0) ? '0      : w_cyq;

    // Stage E: cross products.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_xicy <= 64'(r_cr[CR_LAST].v.xi) * 64'(w_cy);
            r_e_xicx <= 64'(r_cr[CR_LAST].v.xi) * 64'(w_cx);
            r_e_ezcx <= 66'(r_cr[CR_LAST].ez) * 66'(w_cx);
            r_e_ezcy <= 66'(r_cr[CR_LAST].ez) * 66'(w_cy);
            r_e_er   <= 65'(r_cr[CR_LAST].v.eta) * 65'(signed'({1'b0, r_rd[DIV_LAT]}));
            r_e_x    <= r_cr[CR_LAST].v.x;
            r_e_y    <= r_cr[CR_LAST].v.y;
            r_e_z    <= r_cr[CR_LAST].v.z;
            r_e_f    <= r_fd[DIV_LAT];
        end
    end

    // Stage F: numerators in Q.58.
    assign w_n0 = (66'(r_e_x) <<< 28) - 66'(r_e_xicy) - r_e_ezcx;
    assign w_n1 = (66'(r_e_y) <<< 28) + 66'(r_e_xicx) - r_e_ezcy;
    assign w_n2 = (66'(r_e_z) <<< 28) + 66'(r_e_er);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_n0 <= w_n0[63:0];
            r_f_n1 <= w_n1[63:0];
            r_f_n2 <= w_n2[63:0];
            r_f_f  <= r_e_f;
        end
    end

    // Divide by f and saturate.
    tpdc_div u_div_sx (
        .i_clk (i_clk), .i_en (w_en), .i_num (r_f_n0),
        .i_den ({1'b0, r_f_f}), .o_quo (w_sx)
    );
    tpdc_div u_div_sy (
        .i_clk (i_clk), .i_en (w_en), .i_num (r_f_n1),
        .i_den ({1'b0, r_f_f}), .o_quo (w_sy)
    );
    tpdc_div u_div_sz (
        .i_clk (i_clk), .i_en (w_en), .i_num (r_f_n2),
        .i_den ({1'b0, r_f_f}), .o_quo (w_sz)
    );

    // Skid: hold a result the sink refuses so the pipeline may advance once more.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (w_en && w_last && !o_out.ready) begin
            r_skid_vld <= 1'b1;
        end else if (r_skid_vld && o_out.ready) begin
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_skid_x <= to_word(w_sx);
            r_skid_y <= to_word(w_sy);
            r_skid_z <= to_word(w_sz);
        end
    end

    assign o_out.valid  = r_skid_vld || w_last;
    assign o_out.star_x = r_skid_vld ? r_skid_x : to_word(w_sx);
    assign o_out.star_y = r_skid_vld ? r_skid_y : to_word(w_sy);
    assign o_out.star_z = r_skid_vld ? r_skid_z : to_word(w_sz);

endmodule

`default_nettype wire

/* src/tpdc_checker.sv */
// Port-level checks for the tangent-plane pipeline, bound to the top level.
// Depends on tpdc_pkg and tangent_plane_to_direction_cosines.
`default_nettype none

module tpdc_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           i_in_ready,
    input wire logic                           i_out_valid,
    input wire logic                           i_out_ready,
    input wire logic [tpdc_pkg::WORD_BITS-1:0] i_star_x,
    input wire logic [tpdc_pkg::WORD_BITS-1:0] i_star_y,
    input wire logic [tpdc_pkg::WORD_BITS-1:0] i_star_z
);
    import tpdc_pkg::*;

    localparam int CNT_MAX  = PIPE_DEPTH + 1;
    localparam int CNT_BITS = $clog2(CNT_MAX + 2) + 1;

    logic [CNT_BITS-1:0] r_cnt;
    logic [CNT_BITS-1:0] n_cnt;

    // Track items inside the block.
    always_comb begin
        n_cnt = r_cnt;
        if (i_in_valid && i_in_ready) begin
            n_cnt = n_cnt + 1'b1;
        end
        if (i_out_valid && i_out_ready) begin
            n_cnt = n_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_cnt != '0))
        else $error("result shown with no item inside");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_BITS'(CNT_MAX))
        else $error("more items inside than the pipeline holds");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_star_x) && $stable(i_star_y) && $stable(i_star_z)))
        else $error("stalled result changed");

    a_resume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready) |=> i_in_ready)
        else $error("input not ready after a result was taken");

endmodule

bind tangent_plane_to_direction_cosines tpdc_checker u_tpdc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_star_x    (o_out.star_x),
    .i_star_y    (o_out.star_y),
    .i_star_z    (o_out.star_z)
);

`default_nettype wire
